// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) else $error(msg);

// Antecedent in a cycle implies consequent in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent in a cycle implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/rcsp_pkg.sv -----
// ----------------------------------------------------------------------------
// rcsp_pkg
// Shared constants and types for the reference-counted slot pool.
// ----------------------------------------------------------------------------
package rcsp_pkg;

    localparam int SLOTS   = 8;
    localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int IDX_W   = 3;
    localparam int FUNC_W  = 2;
    localparam int ST_W    = 2;
    localparam int CNT_W   = 8;
    // only slots reachable by the 3-bit index field are searched
    localparam int REACH   = (SLOTS < (1 << IDX_W)) ? SLOTS : (1 << IDX_W);

    localparam logic [FUNC_W-1:0] FUNC_ACQUIRE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RETAIN  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd2;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [ST_W-1:0] ST_NOT_USED  = 2'd2;
    localparam logic [ST_W-1:0] ST_AT_MAX    = 2'd3;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // update to the used-slot map
    typedef struct packed {
        logic               set;
        logic               clr;
        logic [SLOT_AW-1:0] slot;
    } slot_upd_t;

    // view of the used-slot map
    typedef struct packed {
        logic [SLOTS-1:0] in_use;
        logic             any_free;
        logic [IDX_W-1:0] free_slot;
    } slot_view_t;

endpackage

// ----- design/rcsp_ram.sv -----
// ----------------------------------------------------------------------------
// rcsp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rcsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                  aclk,
    input  logic                                  wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/rcsp_slot_map.sv -----
// ----------------------------------------------------------------------------
// rcsp_slot_map
// Used bit per slot and lowest-free-slot search.
// ----------------------------------------------------------------------------
module rcsp_slot_map (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  rcsp_pkg::slot_upd_t   upd,
    output rcsp_pkg::slot_view_t  view
);

    logic [rcsp_pkg::SLOTS-1:0] in_use_reg;
    logic [rcsp_pkg::SLOTS-1:0] in_use_next;

    always_comb begin
        in_use_next = in_use_reg;
        if (upd.set) begin
            in_use_next[upd.slot] = 1'b1;
        end
        if (upd.clr) begin
            in_use_next[upd.slot] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_use_reg <= '0;
        end else begin
            in_use_reg <= in_use_next;
        end
    end

    // priority search, lowest index wins
    always_comb begin
        view.in_use    = in_use_reg;
        view.any_free  = 1'b0;
        view.free_slot = '0;
        for (int i = rcsp_pkg::REACH - 1; i >= 0; i--) begin
            if (!in_use_reg[i]) begin
                view.any_free  = 1'b1;
                view.free_slot = rcsp_pkg::IDX_W'(i);
            end
        end
    end

endmodule

// ----- design/refcounted_slot_pool.sv -----
// Path: the count RAM read and the update-stage registers load on the input accept
//   edge; the update result enters the output register when that stage goes.
// Throughput: one item per cycle; the count RAM is written back by the
//   update stage while the next item's read goes out, with a bypass register
//   when both touch the same slot. An item stalls only on a held result.
// Reset: synchronous, active low; all slots free. The count RAM is not
//   cleared: a free slot reads as count zero through its used bit.
// ----------------------------------------------------------------------------
// refcounted_slot_pool
// Slot pool with per-slot reference counts, acquire / retain / release.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module refcounted_slot_pool (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [rcsp_pkg::FUNC_W-1:0]   s_func,
    input  logic [rcsp_pkg::IDX_W-1:0]    s_slot_index,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rcsp_pkg::ST_W-1:0]     m_status,
    output logic [rcsp_pkg::IDX_W-1:0]    m_slot_out,
    output logic                          m_freed,
    output logic [rcsp_pkg::CNT_W-1:0]    m_count_out
);

    // read stage
    logic                               accept;
    logic [rcsp_pkg::SLOT_AW-1:0]       rd_addr;
    logic [rcsp_pkg::CNT_W-1:0]         rd_data;

    // update stage
    logic                               st1_vld_reg, st1_vld_next;
    logic [rcsp_pkg::FUNC_W-1:0]        st1_func_reg;
    logic [rcsp_pkg::IDX_W-1:0]         st1_idx_reg;
    logic                               byp_sel_reg;
    logic [rcsp_pkg::CNT_W-1:0]         byp_data_reg;
    logic                               st1_go;
    logic                               idx_ok;
    logic [rcsp_pkg::SLOT_AW-1:0]       st1_addr;
    logic                               used;
    logic [rcsp_pkg::CNT_W-1:0]         cnt;
    logic [rcsp_pkg::CNT_W-1:0]         cnt_dec;

    logic                               wr_en;
    logic [rcsp_pkg::SLOT_AW-1:0]       wr_addr;
    logic [rcsp_pkg::CNT_W-1:0]         wr_data;
    rcsp_pkg::slot_upd_t                upd;
    rcsp_pkg::slot_view_t               view;

    logic [rcsp_pkg::ST_W-1:0]          res_status;
    logic [rcsp_pkg::IDX_W-1:0]         res_slot;
    logic                               res_freed;
    logic [rcsp_pkg::CNT_W-1:0]         res_count;

    // output register
    logic                               m_valid_reg, m_valid_next;
    logic [rcsp_pkg::ST_W-1:0]          m_status_reg;
    logic [rcsp_pkg::IDX_W-1:0]         m_slot_out_reg;
    logic                               m_freed_reg;
    logic [rcsp_pkg::CNT_W-1:0]         m_count_out_reg;

    assign st1_go  = st1_vld_reg && (!m_valid_reg || m_ready);
    assign s_ready = !st1_vld_reg || st1_go;
    assign accept  = s_valid && s_ready;
    assign rd_addr = rcsp_pkg::SLOT_AW'(s_slot_index);

    rcsp_ram #(
        .WIDTH (rcsp_pkg::CNT_W),
        .DEPTH (rcsp_pkg::SLOTS)
    ) u_count_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rcsp_slot_map u_slot_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .upd     (upd),
        .view    (view)
    );

    assign st1_vld_next = accept ? 1'b1 : (st1_go ? 1'b0 : st1_vld_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_vld_reg <= 1'b0;
            byp_sel_reg <= 1'b0;
        end else begin
            st1_vld_reg <= st1_vld_next;
            if (accept) begin
                // RAM reads old data on a same-slot write: take the new value here
                byp_sel_reg <= wr_en && (wr_addr == rd_addr);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st1_func_reg <= s_func;
            st1_idx_reg  <= s_slot_index;
            byp_data_reg <= wr_data;
        end
    end

    assign idx_ok   = 32'(st1_idx_reg) < 32'(rcsp_pkg::SLOTS);
    assign st1_addr = rcsp_pkg::SLOT_AW'(st1_idx_reg);
    assign used     = idx_ok && view.in_use[st1_addr];
    // a free slot always reads as count zero
    assign cnt      = used ? (byp_sel_reg ? byp_data_reg : rd_data) : '0;
    assign cnt_dec  = cnt - rcsp_pkg::CNT_W'(1);

    always_comb begin
        wr_en      = 1'b0;
        wr_addr    = st1_addr;
        wr_data    = '0;
        upd.set    = 1'b0;
        upd.clr    = 1'b0;
        upd.slot   = st1_addr;
        res_status = rcsp_pkg::ST_OK;
        res_slot   = st1_idx_reg;
        res_freed  = 1'b0;
        res_count  = cnt;
        case (st1_func_reg)
            rcsp_pkg::FUNC_ACQUIRE: begin
                res_slot = view.free_slot;
                if (view.any_free) begin
                    wr_en     = st1_go;
                    wr_addr   = rcsp_pkg::SLOT_AW'(view.free_slot);
                    wr_data   = rcsp_pkg::CNT_W'(1);
                    upd.set   = st1_go;
                    upd.slot  = rcsp_pkg::SLOT_AW'(view.free_slot);
                    res_count = rcsp_pkg::CNT_W'(1);
                end else begin
                    res_status = rcsp_pkg::ST_EXHAUSTED;
                    res_slot   = '0;
                    res_count  = '0;
                end
            end
            rcsp_pkg::FUNC_RETAIN: begin
                if (!used) begin
                    res_status = rcsp_pkg::ST_NOT_USED;
                end else if (cnt == rcsp_pkg::CNT_MAX) begin
                    res_status = rcsp_pkg::ST_AT_MAX;
                end else begin
                    wr_en     = st1_go;
                    wr_data   = cnt + rcsp_pkg::CNT_W'(1);
                    res_count = wr_data;
                end
            end
            rcsp_pkg::FUNC_RELEASE: begin
                if (!used) begin
                    res_status = rcsp_pkg::ST_NOT_USED;
                end else begin
                    wr_en     = st1_go;
                    wr_data   = cnt_dec;
                    res_count = cnt_dec;
                    if (cnt_dec == '0) begin
                        upd.clr   = st1_go;
                        res_freed = 1'b1;
                    end
                end
            end
            default: begin
                // unused code: report current count, no change
            end
        endcase
    end

    assign m_valid_next = st1_go ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (st1_go) begin
            m_status_reg    <= res_status;
            m_slot_out_reg  <= res_slot;
            m_freed_reg     <= res_freed;
            m_count_out_reg <= res_count;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_slot_out  = m_slot_out_reg;
    assign m_freed     = m_freed_reg;
    assign m_count_out = m_count_out_reg;

    `ASSERT_IMPL(a_wr_only_on_go, aclk, aresetn, wr_en, st1_go, "count write without update")
    `ASSERT_IMPL(a_set_slot_free, aclk, aresetn, upd.set, !view.in_use[upd.slot], "acquire of a used slot")
    `ASSERT_IMPL(a_clr_slot_used, aclk, aresetn, upd.clr, view.in_use[upd.slot], "release freed a free slot")
    `ASSERT_NEXT(a_stall_holds, aclk, aresetn, st1_vld_reg && !st1_go, st1_vld_reg && $stable(st1_idx_reg), "update stage lost an item")
    `ASSERT_IMPL(a_freed_zero, aclk, aresetn, m_valid_reg && m_freed_reg, m_count_out_reg == '0 && m_status_reg == rcsp_pkg::ST_OK, "freed with nonzero count")

endmodule

// ----- dv/tb_refcounted_slot_pool.sv -----
// ----------------------------------------------------------------------------
// tb_refcounted_slot_pool
// Self-checking bench for the slot pool: a directed table covers reset,
// exhaustion and misuse cases, then random acquire/retain/release traffic with
// one saturating burst, all checked item by item against typed expectations or a behavioural model.
// ----------------------------------------------------------------------------
module tb_refcounted_slot_pool;

    import rcsp_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_IGNORED = 2'd3;
    localparam int DIRECTED_N   = 25;
    localparam int RANDOM_ITEMS = 1650;
    localparam int BURST_AT     = DIRECTED_N + 600;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [IDX_W-1:0] slot;
        logic             freed;
        logic [CNT_W-1:0] count;
    } pool_result_t;

    typedef struct packed {
        logic [FUNC_W-1:0] fn;
        logic [IDX_W-1:0]  idx;
        logic              typed;
        pool_result_t      res;
    } stim_row_t;

    logic              aclk         = 1'b0;
    logic              aresetn      = 1'b0;
    logic              s_valid      = 1'b0;
    logic              s_ready;
    logic [FUNC_W-1:0] s_func       = '0;
    logic [IDX_W-1:0]  s_slot_index = '0;
    logic              m_valid;
    logic              m_ready      = 1'b0;
    logic [ST_W-1:0]   m_status;
    logic [IDX_W-1:0]  m_slot_out;
    logic              m_freed;
    logic [CNT_W-1:0]  m_count_out;

    // shadow of the pool
    logic             slot_used [SLOTS];
    logic [CNT_W-1:0] slot_refs [SLOTS];

    pool_result_t expected_results [$];
    int           mismatch_count = 0;
    int           items_sent     = 0;
    bit           quiet_send     = 1'b0;

    // typed expectations only where obvious; the rest come from the model
    stim_row_t directed_rows [0:DIRECTED_N-1] = '{
        '{FUNC_RETAIN,  3'd0, 1'b1, '{ST_NOT_USED,  3'd0, 1'b0, 8'd0}},
        '{FUNC_RELEASE, 3'd7, 1'b1, '{ST_NOT_USED,  3'd7, 1'b0, 8'd0}},
        '{FUNC_IGNORED, 3'd5, 1'b1, '{ST_OK,        3'd5, 1'b0, 8'd0}},
        '{FUNC_ACQUIRE, 3'd7, 1'b1, '{ST_OK,        3'd0, 1'b0, 8'd1}},
        '{FUNC_ACQUIRE, 3'd0, 1'b1, '{ST_OK,        3'd1, 1'b0, 8'd1}},
        '{FUNC_ACQUIRE, 3'd5, 1'b1, '{ST_OK,        3'd2, 1'b0, 8'd1}},
        '{FUNC_ACQUIRE, 3'd2, 1'b1, '{ST_OK,        3'd3, 1'b0, 8'd1}},
        '{FUNC_ACQUIRE, 3'd6, 1'b1, '{ST_OK,        3'd4, 1'b0, 8'd1}},
        '{FUNC_ACQUIRE, 3'd1, 1'b1, '{ST_OK,        3'd5, 1'b0, 8'd1}},
        '{FUNC_ACQUIRE, 3'd3, 1'b1, '{ST_OK,        3'd6, 1'b0, 8'd1}},
        '{FUNC_ACQUIRE, 3'd4, 1'b1, '{ST_OK,        3'd7, 1'b0, 8'd1}},
        '{FUNC_ACQUIRE, 3'd3, 1'b1, '{ST_EXHAUSTED, 3'd0, 1'b0, 8'd0}},
        '{FUNC_RETAIN,  3'd3, 1'b0, '0},
        '{FUNC_IGNORED, 3'd3, 1'b0, '0},
        '{FUNC_RELEASE, 3'd3, 1'b0, '0},
        '{FUNC_RELEASE, 3'd3, 1'b0, '0},
        '{FUNC_RELEASE, 3'd3, 1'b1, '{ST_NOT_USED,  3'd3, 1'b0, 8'd0}},
        '{FUNC_IGNORED, 3'd3, 1'b1, '{ST_OK,        3'd3, 1'b0, 8'd0}},
        '{FUNC_ACQUIRE, 3'd6, 1'b0, '0},
        '{FUNC_RELEASE, 3'd0, 1'b0, '0},
        '{FUNC_RELEASE, 3'd7, 1'b0, '0},
        '{FUNC_ACQUIRE, 3'd0, 1'b0, '0},
        '{FUNC_ACQUIRE, 3'd0, 1'b0, '0},
        '{FUNC_RETAIN,  3'd7, 1'b0, '0},
        '{FUNC_ACQUIRE, 3'd0, 1'b1, '{ST_EXHAUSTED, 3'd0, 1'b0, 8'd0}}
    };

    refcounted_slot_pool u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_slot_index (s_slot_index),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_slot_out   (m_slot_out),
        .m_freed      (m_freed),
        .m_count_out  (m_count_out)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 200) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    // applies one operation to the shadow pool and returns its result
    function automatic pool_result_t apply_pool_op(input logic [FUNC_W-1:0] fn,
                                                   input logic [IDX_W-1:0]  idx);
        pool_result_t r;
        bit           found;
        bit           in_range;
        r        = '0;
        r.slot   = idx;
        found    = 1'b0;
        in_range = int'(idx) < SLOTS;
        case (fn)
            FUNC_ACQUIRE: begin
                r.slot = '0;
                for (int i = 0; i < REACH; i++) begin
                    if (!found && !slot_used[i]) begin
                        found        = 1'b1;
                        slot_used[i] = 1'b1;
                        slot_refs[i] = 8'd1;
                        r.slot       = IDX_W'(i);
                        r.count      = 8'd1;
                    end
                end
                r.status = found ? ST_OK : ST_EXHAUSTED;
            end
            FUNC_RETAIN, FUNC_RELEASE: begin
                if (!in_range) begin
                    r.status = ST_NOT_USED;
                end else if (!slot_used[idx]) begin
                    r.status = ST_NOT_USED;
                end else if (fn == FUNC_RETAIN) begin
                    if (slot_refs[idx] == CNT_MAX) begin
                        r.status = ST_AT_MAX;
                    end else begin
                        slot_refs[idx] = slot_refs[idx] + 8'd1;
                        r.status = ST_OK;
                    end
                    r.count = slot_refs[idx];
                end else begin
                    slot_refs[idx] = slot_refs[idx] - 8'd1;
                    r.status = ST_OK;
                    if (slot_refs[idx] == '0) begin
                        slot_used[idx] = 1'b0;
                        r.freed = 1'b1;
                    end
                    r.count = slot_refs[idx];
                end
            end
            default: begin
                r.status = ST_OK;
                r.count  = in_range ? slot_refs[idx] : '0;
            end
        endcase
        return r;
    endfunction

    function automatic bit pick_used_slot(output logic [IDX_W-1:0] idx);
        int n;
        int k;
        n   = 0;
        idx = '0;
        for (int i = 0; i < REACH; i++) begin
            if (slot_used[i]) n++;
        end
        if (n == 0) return 1'b0;
        k = $urandom_range(n - 1);
        for (int i = 0; i < REACH; i++) begin
            if (slot_used[i]) begin
                if (k == 0) idx = IDX_W'(i);
                k--;
            end
        end
        return 1'b1;
    endfunction

    // mostly no gap, some short, a few long
    function automatic int idle_len();
        int p;
        p = $urandom_range(99);
        if (p < 60) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_item(input logic [FUNC_W-1:0] fn, input logic [IDX_W-1:0] idx,
                             input bit typed, input pool_result_t typed_res);
        int           gap;
        pool_result_t pred;
        if ($urandom_range(99) == 0) quiet_send = !quiet_send;
        gap = quiet_send ? 0 : idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_func       <= fn;
        s_slot_index <= idx;
        do @(posedge aclk); while (!s_ready);
        pred = apply_pool_op(fn, idx);
        expected_results.push_back(typed ? typed_res : pred);
        items_sent++;
    endtask

    // called on the edge that accepted the last item
    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin : result_check
        pool_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected item st=%0d slot=%0d fr=%0d cnt=%0d",
                                          m_status, m_slot_out, m_freed, m_count_out));
            end else begin
                e = expected_results.pop_front();
                if (m_status !== e.status || m_slot_out !== e.slot ||
                    m_freed !== e.freed || m_count_out !== e.count) begin
                    report_mismatch($sformatf(
                        "got st=%0d slot=%0d fr=%0d cnt=%0d, want st=%0d slot=%0d fr=%0d cnt=%0d",
                        m_status, m_slot_out, m_freed, m_count_out,
                        e.status, e.slot, e.freed, e.count));
                end
            end
        end
    end

    // result-side back-pressure: ready runs with stalls, now and then a long clean run
    initial begin : sink_stall
        int run;
        int stall;
        forever begin
            run = ($urandom_range(9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
            m_ready <= 1'b1;
            repeat (run) @(posedge aclk);
            stall = idle_len();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    initial begin : stimulus
        logic [IDX_W-1:0] hot;
        logic [IDX_W-1:0] pick;
        bit               have;
        bit               burst_done;
        int               p;
        burst_done = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            slot_used[i] = 1'b0;
            slot_refs[i] = '0;
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIRECTED_N; i++) begin
            send_item(directed_rows[i].fn, directed_rows[i].idx,
                      directed_rows[i].typed, directed_rows[i].res);
        end

        while (items_sent < DIRECTED_N + RANDOM_ITEMS) begin
            if (!burst_done && items_sent >= BURST_AT) begin
                // drive one slot into saturation and back down to free
                burst_done = 1'b1;
                drain_results();
                if (!pick_used_slot(hot)) begin
                    send_item(FUNC_ACQUIRE, IDX_W'($urandom), 1'b0, '0);
                    void'(pick_used_slot(hot));
                end
                while (slot_refs[hot] != CNT_MAX) send_item(FUNC_RETAIN, hot, 1'b0, '0);
                repeat (4) send_item(FUNC_RETAIN, hot, 1'b0, '0);
                while (slot_used[hot]) send_item(FUNC_RELEASE, hot, 1'b0, '0);
            end else begin
                p    = $urandom_range(99);
                have = pick_used_slot(pick);
                if (p < 25) begin
                    send_item(FUNC_ACQUIRE, IDX_W'($urandom), 1'b0, '0);
                end else if (p < 50 && have) begin
                    send_item(FUNC_RETAIN, pick, 1'b0, '0);
                end else if (p < 85 && have) begin
                    send_item(FUNC_RELEASE, pick, 1'b0, '0);
                end else begin
                    send_item(FUNC_W'($urandom), IDX_W'($urandom), 1'b0, '0);
                end
            end
        end

        drain_results();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin : watchdog
        #1000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
